// ===== rtl/synth_divider_rfreq_calc_top_defines.svh =====
// Assertion helpers for the top-level RTL file.
`ifndef SYNTH_DIVIDER_RFREQ_CALC_TOP_DEFINES_SVH
`define SYNTH_DIVIDER_RFREQ_CALC_TOP_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define SRFC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SRFC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/srfc_pkg.sv =====
package srfc_pkg;

   typedef struct packed {
      logic [31:0] target_freq;
      logic        device_offline;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  hs_div_code;
      logic [6:0]  n1_code;
      logic [37:0] rfreq;
   } rsp_type;

   localparam logic [1:0] STATUS_SMALL  = 2'd0;
   localparam logic [1:0] STATUS_FULL   = 2'd1;
   localparam logic [1:0] STATUS_REJECT = 2'd2;

   localparam logic [1:0] CSR_DCO_MIN  = 2'd0;
   localparam logic [1:0] CSR_DCO_MAX  = 2'd1;
   localparam logic [1:0] CSR_CRYSTAL  = 2'd2;
   localparam logic [1:0] CSR_FINE_PPM = 2'd3;

   localparam logic [12:0] DCO_MIN_RESET  = 13'd4850;
   localparam logic [12:0] DCO_MAX_RESET  = 13'd5670;
   localparam logic [31:0] CRYSTAL_RESET  = 32'd1917384130;
   localparam logic [15:0] FINE_PPM_RESET = 16'd3500;

   localparam int DIVIDEND_W = 80;
   localparam int QUOT_W     = 41;
   localparam logic [6:0]  STEPS_BIG   = 7'd80;
   localparam logic [6:0]  STEPS_SMALL = 7'd16;
   localparam logic [10:0] N_NONE      = 11'd1408;  // 11*128, never chosen
   localparam logic [2:0]  HS_LAST     = 3'd5;

   typedef struct packed {
      logic       start;
      logic [6:0] steps;
   } div_ctl_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic              ovf;
      logic [QUOT_W-1:0] quot;
   } div_stat_type;

   // high-speed divider candidates, largest first
   function automatic logic [3:0] hs_value(input logic [2:0] k);
      logic [3:0] v;
      case (k)
         3'd0:    v = 4'd11;
         3'd1:    v = 4'd9;
         3'd2:    v = 4'd7;
         3'd3:    v = 4'd6;
         3'd4:    v = 4'd5;
         default: v = 4'd4;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/srfc_div.sv =====
module srfc_div
   import srfc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  div_ctl_type           div_ctl,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [31:0]           divisor,
   output div_stat_type          div_stat
);

   logic [DIVIDEND_W-1:0] dvd_ff, dvd_in;
   logic [31:0]           dsr_ff, dsr_in;
   logic [31:0]           rem_ff, rem_in;
   logic [QUOT_W-1:0]     quot_ff, quot_in;
   logic                  ovf_ff, ovf_in;
   logic [6:0]            cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   logic [32:0] rem_sh;
   logic [31:0] rem_sub;
   logic        ge;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   assign rem_sh  = {rem_ff, dvd_ff[DIVIDEND_W-1]};
   assign ge      = rem_sh >= {1'b0, dsr_ff};
   // when ge holds the difference is below the divisor, so 32 bits carry it
   assign rem_sub = rem_sh[31:0] - dsr_ff;

   always_comb begin
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      ovf_in  = ovf_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_ctl.start) begin
         dvd_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
         quot_in = '0;
         ovf_in  = 1'b0;
         cnt_in  = div_ctl.steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in  = {dvd_ff[DIVIDEND_W-2:0], 1'b0};
         rem_in  = ge ? rem_sub : rem_sh[31:0];
         ovf_in  = ovf_ff | quot_ff[QUOT_W-1];
         quot_in = {quot_ff[QUOT_W-2:0], ge};
         cnt_in  = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff  <= dvd_in;
      dsr_ff  <= dsr_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      ovf_ff  <= ovf_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_stat.busy = busy_ff;
   assign div_stat.done = done_ff;
   assign div_stat.ovf  = ovf_ff;
   assign div_stat.quot = quot_ff;

endmodule

// ===== rtl/synth_divider_rfreq_calc_top.sv =====
// Channel  Ports                        Carries
// req      req_valid/req_stall/req_payload  target frequency, offline flag
// rsp      rsp_valid/rsp_stall/rsp_payload  status, divider codes, RFREQ
//
// The block works on one item at a time: the next is accepted only once the last
// has reached the result register. The full search runs the shared restoring
// divider more often than a small step (rejects end earlier); the divider runs 16
// steps per small quotient and 80 for RFREQ. Synchronous reset restores the register
// defaults and clears the stored divider set. A finished item waits in
// the result register while the next item is taken; the block stalls input while
// it works or while a second result is ready and the result register is held.
module synth_divider_rfreq_calc_top
   import srfc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_payload,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

`include "synth_divider_rfreq_calc_top_defines.svh"

   typedef enum logic [3:0] {
      S_IDLE, S_WIN, S_WCMP, S_DIV0, S_DIV0_WAIT, S_HS, S_HS_WAIT, S_SEL,
      S_MUL, S_DCO, S_BIG, S_BIG_WAIT, S_DONE
   } state_type;

   state_type    state_ff, state_in;
   req_type      item_ff, item_in;
   logic         small_ff, small_in;
   logic [31:0]  d_ff, d_in;
   logic [31:0]  lim_ff, lim_in;
   logic [15:0]  n0_ff, n0_in;
   logic [2:0]   k_ff, k_in;
   logic [10:0]  best_n_ff, best_n_in;
   logic [7:0]   best_n1_ff, best_n1_in;
   logic [3:0]   best_hs_ff, best_hs_in;
   logic [10:0]  n_ff, n_in;
   logic [42:0]  prod_ff, prod_in;
   rsp_type      res_ff, res_in;
   rsp_type      rsp_ff, rsp_in;
   logic         rsp_valid_ff, rsp_valid_in;

   logic [12:0]  dco_min_ff, dco_min_in;
   logic [12:0]  dco_max_ff, dco_max_in;
   logic [31:0]  xtal_ff, xtal_in;
   logic [15:0]  ppm_ff, ppm_in;

   logic [31:0]  centre_ff, centre_in;
   logic [10:0]  total_div_ff, total_div_in;
   logic [7:0]   slow_div_ff, slow_div_in;
   logic [3:0]   fast_div_ff, fast_div_in;

   div_ctl_type           div_ctl;
   div_stat_type          div_stat;
   logic [DIVIDEND_W-1:0] div_dividend;
   logic [31:0]           div_divisor;

   logic [35:0] d15;
   logic [16:0] n1_raw;
   logic [7:0]  n1_even;
   logic [10:0] cand;
   logic [3:0]  hs_cur;
   logic [13:0] dco_lim_sum;
   logic [40:0] q_p1;
   logic        big_fail;
   rsp_type     reject_res;

   srfc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_ctl  (div_ctl),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .div_stat (div_stat)
   );

   assign hs_cur      = hs_value(k_ff);
   assign d15         = {d_ff, 4'b0} - {4'b0, d_ff};
   assign n1_raw      = {1'b0, div_stat.quot[15:0]} + 17'd1;
   assign n1_even     = (n1_raw[7:0] != 8'd1 && n1_raw[0]) ? n1_raw[7:0] + 8'd1
                                                            : n1_raw[7:0];
   assign cand        = 11'(hs_cur) * 11'(n1_even);
   assign dco_lim_sum = {1'b0, dco_max_ff} + 14'd4;
   assign q_p1        = {1'b0, div_stat.quot[39:0]} + 41'd1;
   assign big_fail    = div_stat.ovf || div_stat.quot[40] || (q_p1[40:39] != 2'b00);
   assign reject_res  = '{status: STATUS_REJECT, hs_div_code: 3'd0, n1_code: 7'd0,
                          rfreq: 38'd0};

   always_comb begin
      div_ctl.start = 1'b0;
      div_ctl.steps = STEPS_SMALL;
      div_dividend  = {{dco_min_ff, 3'b0}, 64'b0};
      div_divisor   = {18'b0, item_ff.target_freq[31:18]};
      case (state_ff)
         S_DIV0: div_ctl.start = 1'b1;
         S_HS: begin
            div_ctl.start = 1'b1;
            div_dividend  = {n0_ff, 64'b0};
            div_divisor   = {28'b0, hs_cur};
         end
         S_BIG: begin
            div_ctl.start = 1'b1;
            div_ctl.steps = STEPS_BIG;
            div_dividend  = {5'b0, prod_ff, 32'b0};
            div_divisor   = xtal_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      small_in     = small_ff;
      d_in         = d_ff;
      lim_in       = lim_ff;
      n0_in        = n0_ff;
      k_in         = k_ff;
      best_n_in    = best_n_ff;
      best_n1_in   = best_n1_ff;
      best_hs_in   = best_hs_ff;
      n_in         = n_ff;
      prod_in      = prod_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      centre_in    = centre_ff;
      total_div_in = total_div_ff;
      slow_div_in  = slow_div_ff;
      fast_div_in  = fast_div_ff;
      dco_min_in   = dco_min_ff;
      dco_max_in   = dco_max_ff;
      xtal_in      = xtal_ff;
      ppm_in       = ppm_ff;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_DCO_MIN:  dco_min_in = csr_wdata[12:0];
            CSR_DCO_MAX:  dco_max_in = csr_wdata[12:0];
            CSR_CRYSTAL:  xtal_in    = csr_wdata;
            CSR_FINE_PPM: ppm_in     = csr_wdata[15:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in  = req_payload;
               state_in = S_WIN;
            end
         end
         S_WIN: begin
            d_in     = (item_ff.target_freq >= centre_ff) ?
                       item_ff.target_freq - centre_ff : centre_ff - item_ff.target_freq;
            lim_in   = centre_ff[31:16] * ppm_ff;
            state_in = S_WCMP;
         end
         S_WCMP: begin
            best_n_in  = N_NONE;
            best_n1_in = 8'd0;
            best_hs_in = 4'd0;
            k_in       = 3'd0;
            small_in   = 1'b0;
            if (ppm_ff != 16'd0 && !item_ff.device_offline && total_div_ff != 11'd0 &&
                d15 <= {4'b0, lim_ff}) begin
               small_in = 1'b1;
               n_in     = total_div_ff;
               state_in = S_MUL;
            end else if (item_ff.target_freq[31:18] == 14'd0) begin
               res_in   = reject_res;
               state_in = S_DONE;
            end else begin
               state_in = S_DIV0;
            end
         end
         S_DIV0: state_in = S_DIV0_WAIT;
         S_DIV0_WAIT: begin
            if (div_stat.done) begin
               n0_in    = div_stat.quot[15:0];
               state_in = S_HS;
            end
         end
         S_HS: state_in = S_HS_WAIT;
         S_HS_WAIT: begin
            if (div_stat.done) begin
               if (n1_raw <= 17'd128 && best_n_ff > cand) begin
                  best_n_in  = cand;
                  best_n1_in = n1_even;
                  best_hs_in = hs_cur;
               end
               k_in     = k_ff + 3'd1;
               state_in = (k_ff == HS_LAST) ? S_SEL : S_HS;
            end
         end
         S_SEL: begin
            if (best_hs_ff == 4'd0) begin
               res_in   = reject_res;
               state_in = S_DONE;
            end else begin
               n_in     = best_n_ff;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = item_ff.target_freq * n_ff;
            state_in = S_DCO;
         end
         S_DCO: begin
            if (prod_ff[42:24] > {8'b0, dco_lim_sum[13:3]}) begin
               res_in   = reject_res;
               state_in = S_DONE;
            end else begin
               state_in = S_BIG;
            end
         end
         S_BIG: state_in = S_BIG_WAIT;
         S_BIG_WAIT: begin
            if (div_stat.done) begin
               state_in = S_DONE;
               if (big_fail) begin
                  res_in = reject_res;
               end else if (small_ff) begin
                  res_in = '{status: STATUS_SMALL, hs_div_code: 3'(fast_div_ff - 4'd4),
                             n1_code: 7'(slow_div_ff - 8'd1), rfreq: q_p1[38:1]};
               end else begin
                  res_in = '{status: STATUS_FULL, hs_div_code: 3'(best_hs_ff - 4'd4),
                             n1_code: 7'(best_n1_ff - 8'd1), rfreq: q_p1[38:1]};
                  total_div_in = n_ff;
                  slow_div_in  = best_n1_ff;
                  fast_div_in  = best_hs_ff;
                  centre_in    = item_ff.target_freq;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      small_ff   <= small_in;
      d_ff       <= d_in;
      lim_ff     <= lim_in;
      n0_ff      <= n0_in;
      k_ff       <= k_in;
      best_n_ff  <= best_n_in;
      best_n1_ff <= best_n1_in;
      best_hs_ff <= best_hs_in;
      n_ff       <= n_in;
      prod_ff    <= prod_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         dco_min_ff   <= DCO_MIN_RESET;
         dco_max_ff   <= DCO_MAX_RESET;
         xtal_ff      <= CRYSTAL_RESET;
         ppm_ff       <= FINE_PPM_RESET;
         centre_ff    <= '0;
         total_div_ff <= '0;
         slow_div_ff  <= '0;
         fast_div_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         dco_min_ff   <= dco_min_in;
         dco_max_ff   <= dco_max_in;
         xtal_ff      <= xtal_in;
         ppm_ff       <= ppm_in;
         centre_ff    <= centre_in;
         total_div_ff <= total_div_in;
         slow_div_ff  <= slow_div_in;
         fast_div_ff  <= fast_div_in;
      end
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `SRFC_ASSERT_NOW(a_reject_zero, rsp_valid_ff && rsp_ff.status == STATUS_REJECT,
      rsp_ff.hs_div_code == 3'd0 && rsp_ff.n1_code == 7'd0 && rsp_ff.rfreq == 38'd0,
      "rejected item carries nonzero fields")
   `SRFC_ASSERT_NOW(a_n1_even, rsp_valid_ff && rsp_ff.status != STATUS_REJECT,
      rsp_ff.n1_code == 7'd0 || rsp_ff.n1_code[0],
      "slow divider is neither one nor even")
   `SRFC_ASSERT_NOW(a_div_owner, div_stat.busy,
      state_ff == S_DIV0_WAIT || state_ff == S_HS_WAIT || state_ff == S_BIG_WAIT,
      "divider runs outside a wait state")
   `SRFC_ASSERT_NEXT(a_take_busy, req_valid && !req_stall, state_ff == S_WIN,
      "accepted item did not start the sequence")

endmodule
